// ----- rtl/cws_pkg.sv -----
package cws_pkg;

  localparam int unsigned WordW = 32;

  localparam logic [WordW-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [WordW-1:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [WordW-1:0] CRC_TOP  = 32'h8000_0000;

  typedef struct packed {
    logic [WordW-1:0] data_word;
    logic             first_word;
    logic             last_word;
  } cws_item_t;

  // Shift a register through one word of zero data bits.
  function automatic logic [WordW-1:0] fold_zero(input logic [WordW-1:0] v);
    logic [WordW-1:0] r;
    r = v;
    for (int n = 0; n < WordW; n++) begin
      r = ((r & CRC_TOP) != '0) ? ({r[WordW-2:0], 1'b0} ^ CRC_POLY) : {r[WordW-2:0], 1'b0};
    end
    return r;
  endfunction

  // Column j is the image of a single set bit j after one full word.
  function automatic logic [WordW-1:0][WordW-1:0] fold_cols();
    logic [WordW-1:0][WordW-1:0] c;
    for (int j = 0; j < WordW; j++) begin
      c[j] = fold_zero(WordW'(1) << j);
    end
    return c;
  endfunction

  localparam logic [WordW-1:0][WordW-1:0] FOLD_COLS = fold_cols();

endpackage

// ----- rtl/cws_in_reg.sv -----
module cws_in_reg
  import cws_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  cws_item_t item_i,
  input  logic      adv_i,
  output logic      valid_o,
  output cws_item_t item_o
);

  logic      valid_q, valid_d;
  cws_item_t item_q;

  assign ready_o = !valid_q || adv_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/cws_fold.sv -----
module cws_fold
  import cws_pkg::*;
(
  input  logic [WordW-1:0] crc_i,
  input  cws_item_t        item_i,
  output logic [WordW-1:0] crc_o
);

  logic [WordW-1:0] x;
  logic [WordW-1:0] acc;

  // Data bits enter at the top, so the word folds as the register XOR the word.
  assign x = (item_i.first_word ? CRC_INIT : crc_i) ^ item_i.data_word;

  always_comb begin
    acc = '0;
    for (int j = 0; j < WordW; j++) begin
      acc = acc ^ (x[j] ? FOLD_COLS[j] : '0);
    end
  end

  assign crc_o = acc;

endmodule

// ----- rtl/cws_out_reg.sv -----
module cws_out_reg
  import cws_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [WordW-1:0] value_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WordW-1:0] value_o
);

  logic             valid_q, valid_d;
  logic [WordW-1:0] value_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      value_q <= value_i;
    end
  end

  assign valid_o = valid_q;
  assign value_o = value_q;

endmodule

// ----- rtl/crc32_word_stream_core.sv -----
// CRC over a stream of 32-bit words, most significant bit first, poly 04C11DB7.
// Input channel: data_word_i, first_word_i, last_word_i under in_valid_i and
// in_ready_o. first_word_i restarts the running register from all ones before
// the word; last_word_i makes the register value after that word a result.
// Output channel: check_value_o under out_valid_o and out_ready_i, one
// transaction per word marked last, none for other words.
// Path: a word accepted into the input register is folded by a single XOR
// network into the running register; for a last word the folded value is
// also loaded into the output register that drives check_value_o.
// Throughput: one word per cycle while the word is not last or the output
// register is free, set by the XOR fold that feeds the running register back to itself.
// Reset: empties both registers and loads the running register with all ones,
// so a stream that starts without first_word_i still starts from all ones.
// Stall: while a result waits for out_ready_i, words that are not last keep
// flowing; a last word holds in the input register and in_ready_o drops until
// the output register frees.
module crc32_word_stream_core
  import cws_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WordW-1:0] data_word_i,
  input  logic             first_word_i,
  input  logic             last_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WordW-1:0] check_value_o
);

  cws_item_t        in_item;
  cws_item_t        s1_item;
  logic             s1_valid;
  logic             s1_adv;
  logic             out_free;
  logic [WordW-1:0] crc_q, crc_d;
  logic [WordW-1:0] crc_fold;

  assign in_item.data_word  = data_word_i;
  assign in_item.first_word = first_word_i;
  assign in_item.last_word  = last_word_i;

  cws_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .adv_i   (s1_adv),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  cws_fold u_fold (
    .crc_i  (crc_q),
    .item_i (s1_item),
    .crc_o  (crc_fold)
  );

  assign s1_adv = s1_valid && (!s1_item.last_word || out_free);

  always_comb begin
    crc_d = crc_q;
    if (s1_adv) begin
      crc_d = crc_fold;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  cws_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s1_adv && s1_item.last_word),
    .value_i (crc_fold),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .value_o (check_value_o)
  );

endmodule

// ----- rtl/cws_checker.sv -----
module cws_checker
  import cws_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [WordW-1:0] data_word_i,
  input logic             first_word_i,
  input logic             last_word_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [WordW-1:0] check_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(check_value_o))
    else $error("result dropped or changed while stalled");

  a_stall_only_downstream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result");

  a_last_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_word_i) ##1 out_ready_i |=> out_valid_o)
    else $error("last word gave no result");

  a_single_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && first_word_i && last_word_i && data_word_i == '0)
     ##1 !out_valid_o |=> out_valid_o && check_value_o == fold_zero(CRC_INIT))
    else $error("wrong check value for a single zero word");

endmodule

bind crc32_word_stream_core cws_checker u_cws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .data_word_i   (data_word_i),
  .first_word_i  (first_word_i),
  .last_word_i   (last_word_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .check_value_o (check_value_o)
);
